>>> rtl/core/tpq_pkg.sv
package tpq_pkg;

    localparam int STAMP_W = 15;
    localparam int ID_W    = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_PEEK   = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    process_id;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    head_id;
        logic [STAMP_W-1:0] head_stamp;
    } out_beat_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } result_t;

    function automatic logic pair_after(entry_t a, entry_t b);
        logic r;
        if (a.stamp != b.stamp) begin
            r = (a.stamp > b.stamp);
        end else begin
            r = (a.id > b.id);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/tpq_ram.sv
module tpq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tpq_ctrl.sv
module tpq_ctrl
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  in_beat_t                       item,
    output logic                           idle,
    output result_t                        result,
    output logic                           wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    output entry_t                         wr_data,
    output logic                           rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    input  entry_t                         rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0]       state_reg,    state_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [PTR_W-1:0] head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg,   wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg,   rd_ptr_next;
    logic [PTR_W-1:0] wk_reg,       wk_next;
    entry_t           head_reg,     head_next;
    entry_t           new_reg,      new_next;

    entry_t           item_entry;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail_ptr;
    out_beat_t        head_beat;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - PTR_W'(1);
    endfunction

    assign item_entry = '{stamp: item.stamp, id: item.process_id};
    assign tail_sum   = SUM_W'(head_ptr_reg) + SUM_W'(count_reg);
    assign tail_ptr   = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S)
                                              : PTR_W'(tail_sum);
    assign head_beat  = '{status: STATUS_OK, head_id: head_reg.id,
                          head_stamp: head_reg.stamp};
    assign idle       = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_ptr_next = head_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        wk_next       = wk_reg;
        head_next     = head_reg;
        new_next      = new_reg;
        wr_en         = 1'b0;
        wr_addr       = wr_ptr_reg;
        wr_data       = new_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg;
        result        = '0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    result.valid = 1'b1;
                    if (item.operation == OP_INSERT) begin
                        if (count_reg == FULL_CNT) begin
                            result.beat        = head_beat;
                            result.beat.status = STATUS_FULL;
                        end else if (count_reg == '0) begin
                            wr_en      = 1'b1;
                            wr_addr    = head_ptr_reg;
                            wr_data    = item_entry;
                            head_next  = item_entry;
                            count_next = CNT_W'(1);
                            result.beat = '{status: STATUS_OK, head_id: item.process_id,
                                            head_stamp: item.stamp};
                        end else begin
                            result.valid = 1'b0;
                            new_next     = item_entry;
                            wr_ptr_next  = tail_ptr;
                            rd_ptr_next  = ptr_dec(tail_ptr);
                            wk_next      = count_reg[PTR_W-1:0];
                            rd_en        = 1'b1;
                            rd_addr      = ptr_dec(tail_ptr);
                            state_next   = S_WALK;
                        end
                    end else if (count_reg == '0) begin
                        result.beat.status = STATUS_EMPTY;
                    end else begin
                        result.beat = head_beat;
                        if (item.operation == OP_POP) begin
                            head_ptr_next = ptr_inc(head_ptr_reg);
                            count_next    = count_reg - CNT_W'(1);
                            if (count_reg > CNT_W'(1)) begin
                                rd_en      = 1'b1;
                                rd_addr    = ptr_inc(head_ptr_reg);
                                state_next = S_LOAD;
                            end
                        end
                    end
                end
            end
            S_WALK: begin
                wr_en = 1'b1;
                if (pair_after(rd_data, new_reg)) begin
                    wr_data     = rd_data;
                    wr_ptr_next = rd_ptr_reg;
                    wk_next     = wk_reg - PTR_W'(1);
                    if (wk_reg == PTR_W'(1)) begin
                        state_next = S_PLACE;
                    end else begin
                        rd_en       = 1'b1;
                        rd_addr     = ptr_dec(rd_ptr_reg);
                        rd_ptr_next = ptr_dec(rd_ptr_reg);
                    end
                end else begin
                    count_next   = count_reg + CNT_W'(1);
                    result.valid = 1'b1;
                    result.beat  = head_beat;
                    state_next   = S_IDLE;
                end
            end
            S_PLACE: begin
                wr_en        = 1'b1;
                head_next    = new_reg;
                count_next   = count_reg + CNT_W'(1);
                result.valid = 1'b1;
                result.beat  = '{status: STATUS_OK, head_id: new_reg.id,
                                 head_stamp: new_reg.stamp};
                state_next   = S_IDLE;
            end
            S_LOAD: begin
                head_next  = rd_data;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_ptr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_ptr_reg <= head_ptr_next;
        end
        wr_ptr_reg <= wr_ptr_next;
        rd_ptr_reg <= rd_ptr_next;
        wk_reg     <= wk_next;
        head_reg   <= head_next;
        new_reg    <= new_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("occupancy above depth");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == S_IDLE)
        else $error("item accepted while busy");

    a_walk_ports: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> wr_addr != rd_addr)
        else $error("read and write collide on one entry");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (start || state_reg == S_WALK || state_reg == S_PLACE))
        else $error("result without a pending item");

    a_walk_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && item.operation == OP_INSERT && !result.valid) |=>
            state_reg == S_WALK)
        else $error("insert walk not started");

endmodule

>>> rtl/core/timestamp_priority_queue.sv
// Peek, pop and insert into an empty or full queue: result registered the cycle after the beat.
// Insert into a partly filled queue: entries after the new one move toward the tail (one RAM
// read and write per cycle), then the new entry fills the gap and its result is registered.
// Pop of a queue with two or more entries passes through a load state that reloads the head.
// Each beat gives one result; a new beat is taken only when idle and the output is free or read.
// Reset (synchronous): occupancy and control state clear; queue entries stay undefined.
module timestamp_priority_queue
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic             ctrl_idle;
    logic             start;
    result_t          result;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    entry_t           rd_data;

    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_payload_reg;

    assign s_ready = ctrl_idle && (!m_valid_reg || m_ready);
    assign start   = s_valid && s_ready;

    tpq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .item    (s_payload),
        .idle    (ctrl_idle),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (result.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (result.valid) begin
            m_payload_reg <= result.beat;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> tb/testbench.sv
module testbench
    import tpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_payload;

    entry_t    sorted_requests[$];
    out_beat_t pending_heads[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int beats_sent;
    int beats_checked;
    int full_seen;
    int empty_seen;
    int peak_fill;
    int stall_cycles;

    timestamp_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic out_beat_t apply_request(in_beat_t req);
        out_beat_t res;
        entry_t    fresh;
        int        pos;
        res = '0;
        fresh.stamp = req.stamp;
        fresh.id = req.process_id;
        if (req.operation == OP_INSERT) begin
            if (sorted_requests.size() >= QUEUE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_requests.size() &&
                       !({sorted_requests[pos].stamp, sorted_requests[pos].id} >
                         {fresh.stamp, fresh.id})) begin
                    pos++;
                end
                sorted_requests.insert(pos, fresh);
                res.status = STATUS_OK;
            end
        end else if (sorted_requests.size() == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.status = STATUS_OK;
        end
        if (sorted_requests.size() > 0) begin
            res.head_id = sorted_requests[0].id;
            res.head_stamp = sorted_requests[0].stamp;
        end
        if (req.operation == OP_POP && sorted_requests.size() > 0) begin
            void'(sorted_requests.pop_front());
        end
        return res;
    endfunction

    // predict on every accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_heads.push_back(apply_request(s_payload));
            beats_sent++;
            if (sorted_requests.size() > peak_fill) begin
                peak_fill = sorted_requests.size();
            end
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_heads.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, m_payload);
                mismatches++;
            end else begin
                want = pending_heads.pop_front();
                beats_checked++;
                if (m_payload.status == STATUS_FULL) begin
                    full_seen++;
                end
                if (m_payload.status == STATUS_EMPTY) begin
                    empty_seen++;
                end
                if (m_payload.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_payload.status);
                    mismatches++;
                end
                if (m_payload.head_id !== want.head_id) begin
                    $display("%0t: head_id expected %0d actual %0d",
                             $time, want.head_id, m_payload.head_id);
                    mismatches++;
                end
                if (m_payload.head_stamp !== want.head_stamp) begin
                    $display("%0t: head_stamp expected %0d actual %0d",
                             $time, want.head_stamp, m_payload.head_stamp);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("timestamp_priority_queue test failed");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [1:0] op, logic [STAMP_W-1:0] stamp,
                             logic [ID_W-1:0] pid);
        in_beat_t beat;
        beat.operation = op;
        beat.stamp = stamp;
        beat.process_id = pid;
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) begin
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_payload <= beat;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic hold_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        hold_sender();
        while (pending_heads.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [STAMP_W-1:0] pick_stamp();
        logic [STAMP_W-1:0] s;
        case ($urandom_range(3))
            0: s = STAMP_W'($urandom_range(7));
            1: s = STAMP_W'($urandom_range(32767, 32760));
            default: s = STAMP_W'($urandom_range(32767));
        endcase
        return s;
    endfunction

    function automatic logic [STAMP_W-1:0] any_stamp();
        return STAMP_W'($urandom_range(32767));
    endfunction

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(15));
    endfunction

    task automatic test_empty_queue();
        send_beat(OP_POP, any_stamp(), any_id());
        send_beat(OP_PEEK, any_stamp(), any_id());
        send_beat(OP_SPARE, any_stamp(), any_id());
    endtask

    task automatic test_extremes_and_ties();
        send_beat(OP_INSERT, 15'h7fff, 4'hf);
        send_beat(OP_INSERT, 15'h7fff, 4'h0);
        send_beat(OP_INSERT, 15'd100, 4'd5);
        send_beat(OP_INSERT, 15'd100, 4'd5);
        send_beat(OP_INSERT, 15'd100, 4'd4);
        send_beat(OP_INSERT, 15'd0, 4'hf);
        send_beat(OP_INSERT, 15'd0, 4'h0);
        send_beat(OP_PEEK, 15'h7fff, 4'hf);
        send_beat(OP_SPARE, 15'h5555, 4'ha);
        repeat (7) send_beat(OP_POP, 15'h2aaa, 4'h5);
        send_beat(OP_POP, 15'd0, 4'd0);
    endtask

    task automatic test_fill_and_overflow();
        repeat (QUEUE_DEPTH) send_beat(OP_INSERT, pick_stamp(), any_id());
        send_beat(OP_INSERT, 15'd0, 4'd0);
        send_beat(OP_INSERT, 15'h7fff, 4'hf);
        send_beat(OP_PEEK, pick_stamp(), any_id());
        repeat (QUEUE_DEPTH + 1) send_beat(OP_POP, pick_stamp(), any_id());
    endtask

    // bursts with shifting insert weight walk the fill level between empty and full
    task automatic test_random_mix(int count);
        int sent;
        int burst;
        int insert_pct;
        int roll;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(60, 10);
            case ($urandom_range(2))
                0: insert_pct = 25;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < insert_pct) begin
                    send_beat(OP_INSERT, pick_stamp(), any_id());
                end else if (roll < insert_pct + 4) begin
                    send_beat(OP_SPARE, any_stamp(), any_id());
                end else if (roll < insert_pct + 12) begin
                    send_beat(OP_PEEK, any_stamp(), any_id());
                end else begin
                    send_beat(OP_POP, any_stamp(), any_id());
                end
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 63;
        mismatches = 0;
        beats_sent = 0;
        beats_checked = 0;
        full_seen = 0;
        empty_seen = 0;
        peak_fill = 0;
        stall_cycles = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_extremes_and_ties();
        test_fill_and_overflow();
        test_random_mix(600);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 25;
        test_random_mix(600);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(600);
        wait_drained();

        $display("%0d beats sent, %0d results checked, %0d mismatches",
                 beats_sent, beats_checked, mismatches);
        $display("full-queue drops %0d, empty-queue results %0d, peak fill %0d of %0d",
                 full_seen, empty_seen, peak_fill, QUEUE_DEPTH);
        if (mismatches == 0 && pending_heads.size() == 0) begin
            $display("timestamp_priority_queue test passed");
        end else begin
            $display("timestamp_priority_queue test failed");
        end
        $finish;
    end

endmodule
